FILE: rtl/mcramp_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel ramp package
// Shared widths, request and result types, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package mcramp_pkg;

    localparam int ACC_W         = 32;  // accumulator and step width
    localparam int TGT_W         = 16;  // integer target width
    localparam int CNT_W         = 15;  // frame counter width
    localparam int OP_W          = 3;
    localparam int NUM_TARGETS   = 6;   // target and value fields carried on the ports
    localparam int MAX_CHANNELS  = 8;
    localparam int DEF_CHANNELS  = 6;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_START_SET = 3'd2,
        OP_SET       = 3'd3,
        OP_STOP      = 3'd4,
        OP_FADE      = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_TICK,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [TGT_W-1:0] target_a;
        logic signed [TGT_W-1:0] target_b;
        logic signed [TGT_W-1:0] target_c;
        logic signed [TGT_W-1:0] target_d;
        logic signed [TGT_W-1:0] target_e;
        logic signed [TGT_W-1:0] target_f;
        logic [CNT_W-1:0]        frame_count;
    } ramp_req_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value_a;
        logic signed [ACC_W-1:0] value_b;
        logic signed [ACC_W-1:0] value_c;
        logic signed [ACC_W-1:0] value_d;
        logic signed [ACC_W-1:0] value_e;
        logic signed [ACC_W-1:0] value_f;
        logic                    active;
        logic [CNT_W-1:0]        ticks_left;
    } ramp_rsp_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_sts_t;

endpackage

FILE: rtl/mcramp_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Divides a signed 32-bit value by a positive 15-bit count, one quotient bit
// per cycle, truncating toward zero; the result wraps to 32 bits.
// ----------------------------------------------------------------------------
module mcramp_div
    import mcramp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  div_ctl_t                ctl,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output div_sts_t                sts
);

    localparam int STEP_W = $clog2(ACC_W);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic                neg_reg,   neg_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [ACC_W-1:0]    quot_reg,  quot_next;
    logic [CNT_W-1:0]    rem_reg,   rem_next;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      trial_diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        step_next  = step_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, quot_reg[ACC_W-1]};
        trial_diff = trial - {1'b0, divisor};
        if (ctl.start) begin
            // Work on the magnitude; the sign is put back at the end.
            neg_next  = dividend[ACC_W-1];
            quot_next = dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next  = trial_diff[CNT_W-1:0];
                quot_next = {quot_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[CNT_W-1:0];
                quot_next = {quot_reg[ACC_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ACC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.done     = done_reg;
    assign sts.quotient = neg_reg ? (~quot_reg + ACC_W'(1)) : quot_reg;

endmodule

FILE: rtl/multi_channel_linear_ramp.sv
// ----------------------------------------------------------------------------
// Multi-channel linear ramp generator
// Fixed-point accumulators that step linearly toward per-channel targets.
// ----------------------------------------------------------------------------
// Start, stop, fade and idle ticks go straight to the report state; a running
// tick walks the channels, one channel add per cycle; a set walks them through
// the divider, one quotient bit per cycle. One request is in work at a time;
// the next is taken the cycle after the result is loaded, even while that
// result waits. Synchronous active-low reset clears the accumulators, steps,
// frame counter and flags.
// ----------------------------------------------------------------------------
module multi_channel_linear_ramp
    import mcramp_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ramp_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ramp_rsp_t m_data
);

    // The channel counter needs at least one bit even for a single channel.
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Sequencer and control state.
    state_t           state_reg,   state_next;
    logic [OP_W-1:0]  op_reg,      op_next;
    logic [CH_W-1:0]  ch_reg,      ch_next;
    logic [CNT_W-1:0] remain_reg,  remain_next;
    logic             running_reg, running_next;
    logic             fade_reg,    fade_next;
    logic             m_valid_reg, m_valid_next;

    // Request targets, held while the set sequence walks the channels.
    // Channels beyond the six target fields see a target of zero.
    logic [TGT_W-1:0] tgt_reg [MAX_CHANNELS];
    logic             tgt_load;

    // Per-channel accumulators and steps.
    logic [ACC_W-1:0] accum_reg [CHANNELS];
    logic [ACC_W-1:0] step_reg  [CHANNELS];
    logic             acc_we;
    logic             acc_clr;
    logic             step_we;

    ramp_rsp_t        m_data_reg;
    logic             rsp_load;

    // Shared datapath for the selected channel.
    logic [ACC_W-1:0] ch_accum;
    logic [ACC_W-1:0] ch_step;
    logic [TGT_W-1:0] ch_tgt;
    logic [ACC_W-1:0] tgt_fixed;
    logic [ACC_W-1:0] diff;
    logic             last_ch;

    div_ctl_t         div_ctl;
    div_sts_t         div_sts;

    logic [ACC_W-1:0] vals [MAX_CHANNELS];

    mcramp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (diff),
        .divisor  (remain_reg),
        .sts      (div_sts)
    );

    assign ch_accum  = accum_reg[ch_reg];
    assign ch_step   = step_reg[ch_reg];
    assign ch_tgt    = tgt_reg[ch_reg];
    assign tgt_fixed = {{(ACC_W - TGT_W){ch_tgt[TGT_W-1]}}, ch_tgt} << FRAC_BITS;
    assign diff      = tgt_fixed - ch_accum;
    assign last_ch   = (ch_reg == CH_W'(CHANNELS - 1));

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            remain_reg  <= '0;
            running_reg <= 1'b0;
            fade_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            remain_reg  <= remain_next;
            running_reg <= running_next;
            fade_reg    <= fade_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg <= op_next;
    end

    // Channel stores. Only one entry is written per cycle, except for the
    // fade clear, which zeroes every accumulator at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                accum_reg[i] <= '0;
                step_reg[i]  <= '0;
            end
        end else begin
            if (acc_clr) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    accum_reg[i] <= '0;
                end
            end else if (acc_we) begin
                accum_reg[ch_reg] <= ch_accum + ch_step;
            end
            if (step_we) begin
                step_reg[ch_reg] <= div_sts.quotient;
            end
        end
    end

    // Target capture and result register hold payload only.
    always_ff @(posedge aclk) begin
        if (tgt_load) begin
            tgt_reg[0] <= s_data.target_a;
            tgt_reg[1] <= s_data.target_b;
            tgt_reg[2] <= s_data.target_c;
            tgt_reg[3] <= s_data.target_d;
            tgt_reg[4] <= s_data.target_e;
            tgt_reg[5] <= s_data.target_f;
            for (int i = NUM_TARGETS; i < MAX_CHANNELS; i++) begin
                tgt_reg[i] <= '0;
            end
        end
        if (rsp_load) begin
            m_data_reg.value_a    <= vals[0];
            m_data_reg.value_b    <= vals[1];
            m_data_reg.value_c    <= vals[2];
            m_data_reg.value_d    <= vals[3];
            m_data_reg.value_e    <= vals[4];
            m_data_reg.value_f    <= vals[5];
            m_data_reg.active     <= running_reg;
            m_data_reg.ticks_left <= remain_reg;
        end
    end

    // Value fields with no channel behind them report zero.
    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            vals[i] = '0;
        end
        for (int i = 0; i < CHANNELS; i++) begin
            vals[i] = accum_reg[i];
        end
    end

    // Sequencer: decodes the request, walks the channels through the divider
    // (set) or the accumulator adder (running tick) where needed, then reports.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        ch_next       = ch_reg;
        remain_next   = remain_reg;
        running_next  = running_reg;
        fade_next     = fade_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        tgt_load      = 1'b0;
        acc_we        = 1'b0;
        acc_clr       = 1'b0;
        step_we       = 1'b0;
        rsp_load      = 1'b0;
        div_ctl.start = 1'b0;
        s_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_data.opcode;
                    tgt_load   = 1'b1;
                    ch_next    = '0;
                    state_next = ST_REPORT;
                    unique case (s_data.opcode)
                        OP_TICK: begin
                            if (running_reg) begin
                                if (remain_reg != '0) begin
                                    state_next = ST_TICK;
                                end else if (fade_reg) begin
                                    // Fade has run out: blank every channel.
                                    acc_clr      = 1'b1;
                                    running_next = 1'b0;
                                end
                            end
                        end
                        OP_START: begin
                            running_next = 1'b1;
                            fade_next    = 1'b0;
                        end
                        OP_START_SET, OP_SET: begin
                            // A frame count of zero behaves as one.
                            remain_next = (s_data.frame_count == '0) ?
                                          CNT_W'(1) : s_data.frame_count;
                            state_next  = ST_DIV_LOAD;
                        end
                        OP_STOP: begin
                            running_next = 1'b0;
                        end
                        OP_FADE: begin
                            fade_next = 1'b1;
                        end
                        default: begin
                            // Unused opcodes only report the state.
                        end
                    endcase
                end
            end
            ST_DIV_LOAD: begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_sts.done) begin
                    step_we = 1'b1;
                    if (last_ch) begin
                        if (op_reg == OP_START_SET) begin
                            running_next = 1'b1;
                            fade_next    = 1'b0;
                        end
                        state_next = ST_REPORT;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_TICK: begin
                acc_we = 1'b1;
                if (last_ch) begin
                    remain_next = remain_reg - CNT_W'(1);
                    state_next  = ST_REPORT;
                end else begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            ST_REPORT: begin
                // Wait for the result register to drain, then snapshot.
                if (!m_valid_reg || m_ready) begin
                    rsp_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/mcramp_checker.sv
// ----------------------------------------------------------------------------
// Ramp port checker
// Watches the request and result channels of the ramp generator.
// ----------------------------------------------------------------------------
module mcramp_checker
    import mcramp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input ramp_req_t s_data,
    input logic      m_valid,
    input logic      m_ready,
    input ramp_rsp_t m_data
);

    // Set while the last accepted request was a stop.
    logic stop_wait_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_wait_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            stop_wait_reg <= (s_data.opcode == OP_STOP);
        end
    end

    // A result that is not taken stays put.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Only one request is in work: an accepted request closes the input.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // Once the block is ready again after a stop, its result shows it stopped.
    a_stop_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_wait_reg && s_ready |-> !m_data.active)
        else $error("stop did not clear the running flag");

endmodule

bind multi_channel_linear_ramp mcramp_checker u_mcramp_checker (.*);

FILE: test/ramp_checker.sv
// ----------------------------------------------------------------------------
// Ramp result checker
// Watches the request and result channels. It predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ramp_checker
    import mcramp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  ramp_req_t s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  ramp_rsp_t m_data,
    output int        fail_count,
    output int        pending
);

    logic [ACC_W-1:0] slope   [NUM_TARGETS];
    logic [ACC_W-1:0] level   [NUM_TARGETS];
    logic [CNT_W-1:0] frames_left;
    logic             running;
    logic             fading;
    ramp_rsp_t        expected_levels [$];

    // Slopes are the remaining distance over the frame count, rounded toward zero.
    task automatic load_slopes(input ramp_req_t req);
        logic signed [TGT_W-1:0] tgt [NUM_TARGETS];
        logic [CNT_W-1:0]        frames;
        logic [ACC_W-1:0]        distance;
        longint                  quot;
        begin
            tgt    = '{req.target_a, req.target_b, req.target_c,
                       req.target_d, req.target_e, req.target_f};
            frames = (req.frame_count == '0) ? CNT_W'(1) : req.frame_count;
            frames_left = frames;
            for (int i = 0; i < NUM_TARGETS; i++) begin
                distance = (ACC_W'(tgt[i]) << DEF_FRAC_BITS) - level[i];
                quot     = longint'($signed(distance)) / longint'(frames);
                slope[i] = quot[ACC_W-1:0];
            end
        end
    endtask

    task automatic apply_request(input ramp_req_t req, output ramp_rsp_t rsp);
        begin
            case (req.opcode)
                OP_TICK: begin
                    if (running && frames_left != '0) begin
                        for (int i = 0; i < NUM_TARGETS; i++)
                            level[i] = level[i] + slope[i];
                        frames_left = frames_left - CNT_W'(1);
                    end else if (running && fading) begin
                        for (int i = 0; i < NUM_TARGETS; i++)
                            level[i] = '0;
                        running = 1'b0;
                    end
                end
                OP_START: begin
                    running = 1'b1;
                    fading  = 1'b0;
                end
                OP_START_SET: begin
                    load_slopes(req);
                    running = 1'b1;
                    fading  = 1'b0;
                end
                OP_SET:  load_slopes(req);
                OP_STOP: running = 1'b0;
                OP_FADE: fading  = 1'b1;
                default: ;
            endcase
            rsp.value_a    = level[0];
            rsp.value_b    = level[1];
            rsp.value_c    = level[2];
            rsp.value_d    = level[3];
            rsp.value_e    = level[4];
            rsp.value_f    = level[5];
            rsp.active     = running;
            rsp.ticks_left = frames_left;
        end
    endtask

    task automatic compare_levels(input ramp_rsp_t exp, input ramp_rsp_t act);
        logic [ACC_W-1:0] ev [NUM_TARGETS];
        logic [ACC_W-1:0] av [NUM_TARGETS];
        string            names [NUM_TARGETS];
        begin
            ev    = '{exp.value_a, exp.value_b, exp.value_c,
                      exp.value_d, exp.value_e, exp.value_f};
            av    = '{act.value_a, act.value_b, act.value_c,
                      act.value_d, act.value_e, act.value_f};
            names = '{"value_a", "value_b", "value_c", "value_d", "value_e", "value_f"};
            for (int i = 0; i < NUM_TARGETS; i++) begin
                if (av[i] !== ev[i]) begin
                    $error("%s: expected %08h, actual %08h", names[i], ev[i], av[i]);
                    fail_count++;
                end
            end
            if (act.active !== exp.active) begin
                $error("active: expected %0b, actual %0b", exp.active, act.active);
                fail_count++;
            end
            if (act.ticks_left !== exp.ticks_left) begin
                $error("ticks_left: expected %0d, actual %0d", exp.ticks_left, act.ticks_left);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        ramp_rsp_t rsp;
        if (!aresetn) begin
            for (int i = 0; i < NUM_TARGETS; i++) begin
                slope[i] = '0;
                level[i] = '0;
            end
            frames_left = '0;
            running     = 1'b0;
            fading      = 1'b0;
            fail_count  = 0;
            expected_levels.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    compare_levels(expected_levels.pop_front(), m_data);
                end
            end
            if (s_valid && s_ready) begin
                apply_request(s_data, rsp);
                expected_levels.push_back(rsp);
            end
        end
        pending = expected_levels.size();
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Multi-channel ramp testbench
// Drives directed and random ramp requests with random idling on both
// channels. A checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import mcramp_pkg::*;

    localparam int ITEMS          = 750;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    // The two opcodes that the block leaves unused.
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam logic signed [TGT_W-1:0] TGT_MAX = 16'sh7FFF;
    localparam logic signed [TGT_W-1:0] TGT_MIN = 16'sh8000;
    localparam logic [CNT_W-1:0]        CNT_MAX = 15'h7FFF;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ramp_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    ramp_rsp_t m_data;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;  // when set, neither side idles

    always #2 aclk = ~aclk;

    multi_channel_linear_ramp dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ramp_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle lengths: mostly none or short, now and then a long pause. While
    // the calm flag is set, both sides run back to back.
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (calm)
                return 0;
            else if (r < 45)
                return 0;
            else if (r < 80)
                return $urandom_range(1, 3);
            else if (r < 96)
                return $urandom_range(4, 12);
            else
                return $urandom_range(20, 60);
        end
    endfunction

    // Targets lean on the extremes and zero so that the distance math sees
    // its corners often.
    function automatic logic signed [TGT_W-1:0] pick_target();
        int r;
        begin
            r = $urandom_range(0, 7);
            case (r)
                0:       return TGT_MAX;
                1:       return TGT_MIN;
                2:       return '0;
                default: return TGT_W'($urandom);
            endcase
        end
    endfunction

    // Frame counts are mostly short so that ramps run to the end and the
    // exhausted and fade cases come up; a few span the whole field.
    function automatic logic [CNT_W-1:0] pick_frames();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                return '0;
            else if (r < 75)
                return CNT_W'($urandom_range(1, 6));
            else if (r < 93)
                return CNT_W'($urandom_range(7, 40));
            else
                return CNT_W'($urandom_range(0, 32767));
        end
    endfunction

    // Even channels take lo and odd channels take hi.
    function automatic ramp_req_t fixed_req(input logic [OP_W-1:0] op,
                                            input logic [CNT_W-1:0] frames,
                                            input logic signed [TGT_W-1:0] lo,
                                            input logic signed [TGT_W-1:0] hi);
        ramp_req_t req;
        begin
            req.opcode      = op;
            req.target_a    = lo;
            req.target_b    = hi;
            req.target_c    = lo;
            req.target_d    = hi;
            req.target_e    = lo;
            req.target_f    = hi;
            req.frame_count = frames;
            return req;
        end
    endfunction

    function automatic ramp_req_t random_req(input logic [OP_W-1:0] op,
                                             input logic [CNT_W-1:0] frames);
        ramp_req_t req;
        begin
            req.opcode      = op;
            req.target_a    = pick_target();
            req.target_b    = pick_target();
            req.target_c    = pick_target();
            req.target_d    = pick_target();
            req.target_e    = pick_target();
            req.target_f    = pick_target();
            req.frame_count = frames;
            return req;
        end
    endfunction

    // Presents one request from a falling edge and holds it until the block
    // takes it. Returns at the falling edge after the handshake, so the next
    // call either keeps valid high or drops it, never both in one step.
    task automatic send_req(input ramp_req_t req);
        int gap;
        begin
            gap = pick_gap();
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid = 1'b1;
            s_data  = req;
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
            items_sent++;
        end
    endtask

    task automatic send_ticks(input int n);
        begin
            repeat (n) send_req(random_req(OP_TICK, CNT_W'($urandom)));
        end
    endtask

    // A well-formed ramp: load and start, tick through the frames (ten at most)
    // and up to two more, then often fade out or stop.
    task automatic run_ramp();
        logic [CNT_W-1:0] frames;
        int               n;
        begin
            frames = pick_frames();
            n      = (frames == '0) ? 1 : int'(frames);
            if ($urandom_range(0, 3) == 0) begin
                send_req(random_req(OP_SET, frames));
                send_req(random_req(OP_START, CNT_W'($urandom)));
            end else begin
                send_req(random_req(OP_START_SET, frames));
            end
            send_ticks(((n < 10) ? n : 10) + $urandom_range(0, 2));
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    send_req(random_req(OP_FADE, CNT_W'($urandom)));
                    send_ticks($urandom_range(1, 3));
                end
                3: begin
                    send_req(random_req(OP_STOP, CNT_W'($urandom)));
                    send_ticks(1);
                end
                default: ;
            endcase
        end
    endtask

    // The result side takes results in runs and stalls between them.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            m_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // The watchdog ends a run in which nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. A tick right after reset must change nothing,
        // and the unused opcodes only report the state.
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_SPARE6, CNT_MAX, TGT_MAX, TGT_MIN));
        send_req(fixed_req(OP_SPARE7, CNT_MAX, TGT_MIN, TGT_MAX));

        // A zero frame count acts as one. The load alone must not start the
        // block, so the next tick is ignored until a start arrives.
        send_req(fixed_req(OP_SET, '0, TGT_MAX, TGT_MIN));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_START, '0, '0, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        // The count is spent and no fade is pending: the state holds.
        send_req(fixed_req(OP_TICK, '0, '0, '0));

        // Climb to the top of the range, then aim at the bottom. The
        // distance wraps to a small positive step and the sum wraps over.
        send_req(fixed_req(OP_SET, 15'd1, TGT_MAX, TGT_MAX));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_SET, 15'd1, TGT_MIN, TGT_MIN));
        send_req(fixed_req(OP_TICK, '0, '0, '0));

        // The longest ramp, then a stop in the middle of it.
        send_req(fixed_req(OP_START_SET, CNT_MAX, TGT_MAX, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_STOP, '0, '0, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));

        // A start drops a fade that was requested before it.
        send_req(fixed_req(OP_FADE, '0, '0, '0));
        send_req(fixed_req(OP_START, '0, '0, '0));

        // Fade out: the first tick spends the count, the next clears the
        // accumulators and stops the block, and the last finds it stopped.
        send_req(fixed_req(OP_START_SET, 15'd1, 16'sd1, -16'sd1));
        send_req(fixed_req(OP_FADE, '0, '0, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));
        send_req(fixed_req(OP_TICK, '0, '0, '0));

        // Random part: mostly complete ramps with random content, the rest
        // short bursts of arbitrary requests.
        while (items_sent < ITEMS) begin
            calm = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) != 0) begin
                run_ramp();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_req(random_req(OP_W'($urandom_range(0, 7)),
                                        CNT_W'($urandom_range(0, 32767))));
            end
        end
        s_valid = 1'b0;

        // Let every result come back, then keep watching for anything the block
        // should not send.
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
